@@ hdl/b2t_pkg.sv @@
// Shared constants and types for the blank-to-tab compressor.
package b2t_pkg;

  // Geometry
  localparam int StopSlots       = 7;
  localparam int DefaultInterval = 8;
  localparam int ColumnBits      = 12;
  localparam int PendBits        = 12;
  localparam int StopBits        = 12;
  localparam int ByteBits        = 8;
  localparam int CountBits       = 3;
  localparam int CfgIdxBits      = 3;
  localparam int CfgDataBits     = 12;

  // Width of column + pending sums and of next-stop values
  localparam int SumBits = ((ColumnBits > PendBits) ? ColumnBits : PendBits) + 1;

  localparam logic [ColumnBits-1:0] ColMax  = {ColumnBits{1'b1}};
  localparam logic [PendBits-1:0]   PendMax = {PendBits{1'b1}};

  // Character codes
  localparam logic [ByteBits-1:0] BlankCode   = 8'd32;
  localparam logic [ByteBits-1:0] NewlineCode = 8'd10;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegStopCount = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStopFirst = 3'd1;

  // Stream widths
  localparam int InDataBits  = 8;
  localparam int OutDataBits = 24;
  localparam int OutUserBits = 2;

  // One result request
  typedef struct packed {
    logic                emit_tab;
    logic [PendBits-1:0] space_count;
    logic                byte_valid;
    logic [ByteBits-1:0] out_byte;
  } result_t;

endpackage

@@ hdl/blank_to_tab_compressor_core.sv @@
// Blank-to-tab compressor core: blank runs become tabs at custom or default stops.
//
// The core takes one text byte per request and returns at most one result per
// byte, one byte per clock cycle while the receiver keeps up: the column and
// pending-blank registers update in the same cycle the byte is taken, and the
// stop search is a parallel compare over the seven stop registers followed by
// a priority pick, so each result sits in the output register in the cycle
// after its byte is taken. A blank that does not reach the next stop produces
// no result. A blank that does, at a stop within the last column, produces a
// tab result (tuser bit 0 set). Any other byte produces a result carrying the
// pending blank count and the byte (tuser bit 1 set); a newline sets the
// column back to zero. The next stop is the first of the stop_count stop
// registers, in register order, that lies beyond the column, else the next
// multiple of the default interval of 8. Blanks still pending when input
// stops are never emitted. Write configuration only while the core is idle.
module blank_to_tab_compressor_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [b2t_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [b2t_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [b2t_pkg::InDataBits-1:0]      s_axis_tdata,   // [7:0] in_byte
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [b2t_pkg::OutDataBits-1:0]     m_axis_tdata,   // [11:0] space_count,
                                                              // [19:12] out_byte, zero pad
  output logic [b2t_pkg::OutUserBits-1:0]     m_axis_tuser    // [0] emit_tab, [1] byte_valid
);

  // Configuration registers
  logic [b2t_pkg::CountBits-1:0] stop_count_q;
  logic [b2t_pkg::StopBits-1:0]  stops_q [b2t_pkg::StopSlots];

  // Tracking state
  logic [b2t_pkg::ColumnBits-1:0] column_q, column_d;
  logic [b2t_pkg::PendBits-1:0]   pend_q, pend_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  b2t_pkg::result_t   out_q, out_d;

  logic                          in_fire;
  logic                          is_blank;
  logic [b2t_pkg::SumBits-1:0]   col_ext;
  logic [b2t_pkg::SumBits-1:0]   dflt_stop;
  logic [b2t_pkg::SumBits-1:0]   next_stop;
  logic [b2t_pkg::StopSlots-1:0] hit;
  logic [b2t_pkg::PendBits-1:0]  pend_inc;
  logic [b2t_pkg::SumBits-1:0]   blank_sum;
  logic [b2t_pkg::SumBits-1:0]   byte_sum;
  logic                          tab_fire;
  logic [b2t_pkg::ColumnBits-1:0] byte_col;

  // Take a new request whenever the output register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_blank      = (s_axis_tdata == b2t_pkg::BlankCode);

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= '0;
      for (int i = 0; i < b2t_pkg::StopSlots; i++) begin
        stops_q[i] <= b2t_pkg::StopBits'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == b2t_pkg::RegStopCount) begin
        stop_count_q <= cfg_wdata_i[b2t_pkg::CountBits-1:0];
      end
      for (int i = 0; i < b2t_pkg::StopSlots; i++) begin
        if (cfg_idx_i == b2t_pkg::RegStopFirst + b2t_pkg::CfgIdxBits'(i)) begin
          stops_q[i] <= cfg_wdata_i[b2t_pkg::StopBits-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Next tab stop for the current column
  // ---------------------------------------------------------------------
  assign col_ext   = b2t_pkg::SumBits'(column_q);
  assign dflt_stop = (col_ext / b2t_pkg::SumBits'(b2t_pkg::DefaultInterval)
                      + b2t_pkg::SumBits'(1))
                     * b2t_pkg::SumBits'(b2t_pkg::DefaultInterval);

  // Flag every active stop register lying beyond the column
  always_comb begin
    for (int i = 0; i < b2t_pkg::StopSlots; i++) begin
      hit[i] = (b2t_pkg::CountBits'(i) < stop_count_q)
               && (b2t_pkg::SumBits'(stops_q[i]) > col_ext);
    end
  end

  // First hit in register order wins, else fall back to the default grid
  always_comb begin
    next_stop = dflt_stop;
    for (int i = b2t_pkg::StopSlots - 1; i >= 0; i--) begin
      if (hit[i]) begin
        next_stop = b2t_pkg::SumBits'(stops_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // State update and result formation
  // ---------------------------------------------------------------------
  assign pend_inc  = (pend_q == b2t_pkg::PendMax) ? pend_q : pend_q + 1'b1;
  assign blank_sum = col_ext + b2t_pkg::SumBits'(pend_inc);
  assign tab_fire  = (next_stop <= b2t_pkg::SumBits'(b2t_pkg::ColMax))
                     && (blank_sum >= next_stop);

  // Column after flushing pending blanks, saturated
  assign byte_sum = col_ext + b2t_pkg::SumBits'(pend_q);
  always_comb begin
    if (byte_sum > b2t_pkg::SumBits'(b2t_pkg::ColMax)) begin
      byte_col = b2t_pkg::ColMax;
    end else begin
      byte_col = byte_sum[b2t_pkg::ColumnBits-1:0];
    end
  end

  always_comb begin
    column_d    = column_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (in_fire) begin
      if (is_blank) begin
        if (tab_fire) begin
          // Jump to the stop and emit a single tab
          column_d          = next_stop[b2t_pkg::ColumnBits-1:0];
          pend_d            = '0;
          out_valid_d       = 1'b1;
          out_d.emit_tab    = 1'b1;
          out_d.space_count = '0;
          out_d.byte_valid  = 1'b0;
          out_d.out_byte    = '0;
        end else begin
          // Hold the blank as pending
          pend_d = pend_inc;
        end
      end else begin
        // Flush pending blanks as a count along with the byte
        out_valid_d       = 1'b1;
        out_d.emit_tab    = 1'b0;
        out_d.space_count = pend_q;
        out_d.byte_valid  = 1'b1;
        out_d.out_byte    = s_axis_tdata;
        pend_d            = '0;
        if (s_axis_tdata == b2t_pkg::NewlineCode) begin
          column_d = '0;
        end else if (byte_col != b2t_pkg::ColMax) begin
          column_d = byte_col + 1'b1;
        end else begin
          column_d = byte_col;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      column_q    <= column_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.out_byte, out_q.space_count};
  assign m_axis_tuser  = {out_q.byte_valid, out_q.emit_tab};

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the blank-to-tab compressor core.
`timescale 1ns / 100ps

module testbench;
  import b2t_pkg::*;

  localparam int ColTop      = ColMax;
  localparam int HoldCycles  = 400;      // long receiver hold-off
  localparam int HoldEvery   = 600;      // results between hold-offs
  localparam int DrainCycles = 8;        // latency margin once the output side is empty
  localparam int CycleLimit  = 1500000;
  localparam int SideSend    = 0;
  localparam int SideRecv    = 1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;    // [7:0] in_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;         // [11:0] space_count, [19:12] out_byte
  logic [OutUserBits-1:0] m_axis_tuser;         // [0] emit_tab, [1] byte_valid

  blank_to_tab_compressor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Text bytes waiting to be offered, and emissions the core still owes us.
  logic [7:0] text_q[$];
  result_t    emitted_q[$];

  // Shadow of the core: output column, blanks not yet emitted, stop registers.
  logic [ColumnBits-1:0] col_now = '0;
  logic [PendBits-1:0]   blanks_held = '0;
  logic [CountBits-1:0]  stop_used = '0;
  logic [StopBits-1:0]   stop_col[StopSlots];

  int mismatches = 0;
  int cycles = 0;
  int out_count = 0;
  int next_hold_at = 150;
  int hold_left = 0;
  int snd_wait = 0;
  int rcv_wait = 0;
  int calm_left[2];
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  initial begin
    for (int k = 0; k < StopSlots; k++) stop_col[k] = 1;
    calm_left[SideSend] = 0;
    calm_left[SideRecv] = 0;
  end

  // Pause before the next request on one side: mostly a random length, with
  // occasional calm stretches with no pause that run back to back.
  function automatic int pick_pause(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = int'($urandom_range(10, 50));
      return 0;
    end
    return int'($urandom_range(0, 17));
  endfunction

  // First enabled stop beyond the column in register order, else the next
  // default multiple; may land past the last column.
  function automatic int upcoming_stop(input int col);
    int i;
    for (i = 0; i < int'(stop_used); i++) begin
      if (int'(stop_col[i]) > col) return int'(stop_col[i]);
    end
    return (col / DefaultInterval + 1) * DefaultInterval;
  endfunction

  // Advance the shadow by one text byte and queue what the core must emit.
  task automatic entab_byte(input logic [7:0] ch);
    int      nx;
    int      sum;
    result_t r;
    r = '0;
    if (ch == BlankCode) begin
      if (blanks_held != PendMax) blanks_held++;
      nx = upcoming_stop(int'(col_now));
      // A stop past the last column never fires; blanks keep piling up.
      if (nx <= ColTop && int'(col_now) + int'(blanks_held) >= nx) begin
        col_now = ColumnBits'(nx);
        blanks_held = '0;
        r.emit_tab = 1'b1;
        emitted_q.push_back(r);
      end
    end else begin
      r.space_count = blanks_held;
      r.byte_valid  = 1'b1;
      r.out_byte    = ch;
      emitted_q.push_back(r);
      sum = int'(col_now) + int'(blanks_held);
      if (sum > ColTop) sum = ColTop;
      if (ch == NewlineCode) sum = 0;
      else if (sum < ColTop) sum++;
      col_now = ColumnBits'(sum);
      blanks_held = '0;
    end
  endtask

  // Input side: predict on every accepted request.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) entab_byte(s_axis_tdata);
  end

  // Driver: hold the request until taken, then pause and offer the next byte.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_taken) snd_wait = pick_pause(SideSend);
      if (snd_wait > 0) begin
        snd_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_count++;
      if (emitted_q.size() == 0) begin
        $error("result with nothing expected: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = emitted_q.pop_front();
        if (m_axis_tuser[0] !== want.emit_tab) begin
          $error("emit_tab: expected %0d, got %0d", want.emit_tab, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata[11:0] !== want.space_count) begin
          $error("space_count: expected %0d, got %0d", want.space_count, m_axis_tdata[11:0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tdata[19:12] !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, m_axis_tdata[19:12]);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random pauses per result, plus a long hold-off every so often so
  // the core backs up and drops s_axis_tready while the driver keeps offering.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_taken) rcv_wait = pick_pause(SideRecv);
      if (out_count >= next_hold_at) begin
        hold_left = HoldCycles;
        next_hold_at += HoldEvery;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rcv_wait > 0) begin
        rcv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write one register while the core is idle and mirror it in the shadow.
  task automatic set_reg(input int idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgIdxBits'(idx);
    cfg_wdata_i <= CfgDataBits'(val);
    if (idx == int'(RegStopCount)) stop_used = CountBits'(val);
    else stop_col[idx - int'(RegStopFirst)] = StopBits'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every byte is taken and every result is back, then let any
  // trailing blank with no result clear the pipeline.
  task automatic settle();
    do @(posedge clk_i);
    while (text_q.size() != 0 || s_axis_tvalid || emitted_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random text: mostly blank runs and words, some newlines, some raw bytes.
  task automatic add_text(input int n);
    int         k;
    int         run;
    int         kind;
    logic [7:0] ch;
    k = 0;
    while (k < n) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 45) begin
        run = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 40))
                                          : int'($urandom_range(1, 12));
        repeat (run) text_q.push_back(BlankCode);
        k += run;
      end else if (kind < 80) begin
        run = int'($urandom_range(1, 6));
        repeat (run) begin
          ch = 8'($urandom_range(33, 126));
          text_q.push_back(ch);
        end
        k += run;
      end else if (kind < 88) begin
        text_q.push_back(NewlineCode);
        k++;
      end else begin
        ch = 8'($urandom_range(0, 255));
        text_q.push_back(ch);
        k++;
      end
    end
  endtask

  task automatic add_blanks(input int n);
    repeat (n) text_q.push_back(BlankCode);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset configuration (default stops every 8 columns):
    // word then blanks up to a stop, short run before the extreme bytes,
    // pending blanks flushed by a newline, full run from column zero.
    text_q.push_back(8'h61);
    add_blanks(7);
    add_blanks(3);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    add_blanks(2);
    text_q.push_back(NewlineCode);
    add_blanks(8);
    add_text(200);
    settle();

    // Sorted custom stops, all slots in use.
    for (int k = 0; k < StopSlots; k++) set_reg(int'(RegStopFirst) + k, 3 + 2 * k * k);
    set_reg(int'(RegStopCount), 7);
    @(posedge clk_i);
    add_text(200);
    settle();

    // Unsorted stops with a zero stop in the middle.
    set_reg(int'(RegStopFirst) + 0, 12);
    set_reg(int'(RegStopFirst) + 1, 0);
    set_reg(int'(RegStopFirst) + 2, 5);
    set_reg(int'(RegStopFirst) + 3, 30);
    set_reg(int'(RegStopCount), 4);
    @(posedge clk_i);
    text_q.push_back(NewlineCode);
    add_blanks(5);
    add_text(200);
    settle();

    // Extreme stop values; past column 17 only the top column qualifies.
    set_reg(int'(RegStopFirst) + 0, 1);
    set_reg(int'(RegStopFirst) + 1, 2);
    set_reg(int'(RegStopFirst) + 2, 6);
    set_reg(int'(RegStopFirst) + 3, 9);
    set_reg(int'(RegStopFirst) + 4, 16);
    set_reg(int'(RegStopFirst) + 5, 17);
    set_reg(int'(RegStopFirst) + 6, ColTop);
    set_reg(int'(RegStopCount), 7);
    @(posedge clk_i);
    add_text(200);
    settle();

    // Random configuration with small stops.
    set_reg(int'(RegStopCount), int'($urandom_range(0, 7)));
    for (int k = 0; k < StopSlots; k++) begin
      set_reg(int'(RegStopFirst) + k, int'($urandom_range(0, 48)));
    end
    @(posedge clk_i);
    add_text(200);
    settle();

    // Single far stop: long blank runs skip the default grid entirely and
    // are flushed as a count with the next byte.
    set_reg(int'(RegStopFirst) + 0, ColTop);
    set_reg(int'(RegStopCount), 1);
    @(posedge clk_i);
    text_q.push_back(NewlineCode);
    add_blanks(40);
    text_q.push_back(8'h78);
    add_blanks(20);
    text_q.push_back(8'h79);
    text_q.push_back(BlankCode);
    text_q.push_back(NewlineCode);
    settle();

    // Random configuration again, ending on blanks with no byte after them.
    for (int k = 0; k < StopSlots; k++) begin
      set_reg(int'(RegStopFirst) + k, int'($urandom_range(1, 200)));
    end
    set_reg(int'(RegStopCount), 7);
    @(posedge clk_i);
    add_text(200);
    add_blanks(3);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
